@@ rtl/scaled_text_framebuffer_writer_macros.svh @@
// ----------------------------------------------------------------------------
// scaled text framebuffer writer assertion macros
// shared concurrent assertion forms, sampled on clk, off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef SCALED_TEXT_FRAMEBUFFER_WRITER_MACROS_SVH
`define SCALED_TEXT_FRAMEBUFFER_WRITER_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define STFW_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define STFW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/stfw_pkg.sv @@
// ----------------------------------------------------------------------------
// stfw_pkg
// types, constants, font table and helpers of the scaled text framebuffer writer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stfw_pkg;

	localparam int DISPLAY_WIDTH_DEF  = 128;
	localparam int DISPLAY_HEIGHT_DEF = 64;

	localparam int TEXT_COLS  = 11;
	localparam int TEXT_PAGES = 7;
	localparam int CELL_PITCH = 11;
	localparam int CELL_W     = 10;

	localparam int GLYPH_COUNT = 39;
	localparam logic [5:0] GLYPH_DIGIT0 = 6'd0;
	localparam logic [5:0] GLYPH_ALPHA0 = 6'd10;
	localparam logic [5:0] GLYPH_COLON  = 6'd36;
	localparam logic [5:0] GLYPH_DASH   = 6'd37;
	localparam logic [5:0] GLYPH_BLANK  = 6'd38;

	typedef enum logic [1:0] {
		REQ_WRITE_CHAR = 2'd0,
		REQ_SET_CURSOR = 2'd1,
		REQ_CLEAR      = 2'd2,
		REQ_READ_BYTE  = 2'd3
	} req_kind_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BASE,
		ST_OFFSET,
		ST_TOP,
		ST_BOTTOM,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_RESP
	} seq_state_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       status;
	} res_t;

	// five glyph columns, leftmost in the top byte, bit 0 is the top row
	localparam logic [39:0] FONT [GLYPH_COUNT] = '{
		40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
		40'h3649494936, 40'h064949291E,
		40'h7E1111117E, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C,
		40'h7F49494941, 40'h7F09090901, 40'h3E4149497A, 40'h7F0808087F,
		40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
		40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906,
		40'h3E4151215E, 40'h7F09192946, 40'h4649494931, 40'h01017F0101,
		40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F, 40'h6314081463,
		40'h0708700807, 40'h6151494543,
		40'h0036360000, 40'h0808080800, 40'h0000000000
	};

	// character code to font row, lower case folds onto upper case
	function automatic logic [5:0] glyph_index(input logic [7:0] code);
		logic [7:0] c;
		logic [5:0] idx;
		c = code;
		if (code >= 8'h61 && code <= 8'h7A) begin
			c = code - 8'h20;
		end
		priority if (c >= 8'h30 && c <= 8'h39) begin
			idx = GLYPH_DIGIT0 + 6'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h5A) begin
			idx = GLYPH_ALPHA0 + 6'(c - 8'h41);
		end else if (c == 8'h3A) begin
			idx = GLYPH_COLON;
		end else if (c == 8'h2D) begin
			idx = GLYPH_DASH;
		end else begin
			idx = GLYPH_BLANK;
		end
		return idx;
	endfunction

	function automatic logic [6:0] glyph_column(input logic [39:0] g, input logic [2:0] k);
		logic [6:0] col;
		unique case (k)
			3'd0:    col = g[38:32];
			3'd1:    col = g[30:24];
			3'd2:    col = g[22:16];
			3'd3:    col = g[14:8];
			3'd4:    col = g[6:0];
			default: col = '0;
		endcase
		return col;
	endfunction

	// each glyph row becomes two pixel rows
	function automatic logic [7:0] spread_rows(input logic [3:0] n);
		logic [7:0] b;
		for (int j = 0; j < 8; j++) begin
			b[j] = n[j >> 1];
		end
		return b;
	endfunction

endpackage

`default_nettype wire

@@ rtl/stfw_req_if.sv @@
// ----------------------------------------------------------------------------
// stfw_req_if
// request channel: valid/ready handshake with the request fields
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface stfw_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] char_code;
	logic [7:0] cursor_column;
	logic [7:0] cursor_page;
	logic [9:0] read_index;

	modport source (
		output valid, req_type, char_code, cursor_column, cursor_page, read_index,
		input  ready
	);
	modport sink (
		input  valid, req_type, char_code, cursor_column, cursor_page, read_index,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/stfw_rsp_if.sv @@
// ----------------------------------------------------------------------------
// stfw_rsp_if
// result channel: valid/ready handshake with read data and status
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface stfw_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       status;

	modport source (
		output valid, read_data, status,
		input  ready
	);
	modport sink (
		input  valid, read_data, status,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/scaled_text_framebuffer_writer.sv @@
// ----------------------------------------------------------------------------
// scaled_text_framebuffer_writer
// 5x7 font drawn 2x into a page-organized monochrome framebuffer
// ----------------------------------------------------------------------------
//
//  port   modport  beat carries                                       dir
//  -----  -------  -------------------------------------------------  ---
//  req    sink     req_type, char_code, cursor_column, cursor_page,   in
//                  read_index
//  rsp    source   read_data, status                                  out
//
// write character: BASE and OFFSET set the cell address, then TOP and BOTTOM
//   write the 10 pixel columns, two pages each, over the single write port
// set cursor: RESP; read byte: RD_ADDR, RD_DATA, RESP; clear: sweep, then RESP
// after reset the clear sweep runs over every store byte with req.ready low
// one request in flight; a finished result sits in the output register while
//   the next request is taken, the sequencer holds when that register is full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "scaled_text_framebuffer_writer_macros.svh"

module scaled_text_framebuffer_writer
	import stfw_pkg::*;
#(
	parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
	parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	stfw_req_if.sink  req,
	stfw_rsp_if.source rsp
);

	// store geometry: DISPLAY_WIDTH bytes per page, pages rounded up
	localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
	localparam int STORE_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
	localparam int AW          = $clog2(STORE_BYTES);

	logic          accept;
	logic          seq_idle;
	logic          res_valid;
	logic          res_ready;
	res_t          res;

	// framebuffer port between sequencer and store
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;

	// output register
	logic          out_valid_q;
	res_t          out_q;

	// request beat taken only while the sequencer waits for work
	assign req.ready = seq_idle;
	assign accept    = req.valid && req.ready;

	stfw_ctrl #(
		.DISPLAY_WIDTH  (DISPLAY_WIDTH),
		.DISPLAY_HEIGHT (DISPLAY_HEIGHT)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.req_type      (req.req_type),
		.char_code     (req.char_code),
		.cursor_column (req.cursor_column),
		.cursor_page   (req.cursor_page),
		.read_index    (req.read_index),
		.idle          (seq_idle),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata)
	);

	stfw_frame_mem #(
		.DEPTH (STORE_BYTES),
		.AW    (AW)
	) u_frame_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// result moves into the output register when it is empty or draining
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = out_q.read_data;
	assign rsp.status    = out_q.status;

	// a taken request always keeps the sequencer busy for the next cycle
	`STFW_ASSERT_NEXT(a_busy_after_accept, accept, !req.ready, "request taken while busy")
	// an ignored character never carries read data
	`STFW_ASSERT_SAME(a_status_no_data, rsp.valid && rsp.status, rsp.read_data == 8'h00,
		"status beat with read data")
	// a handed-over result shows on the result channel next cycle
	`STFW_ASSERT_NEXT(a_result_lands, res_valid && res_ready, rsp.valid, "result lost")

endmodule

`default_nettype wire

@@ rtl/stfw_frame_mem.sv @@
// ----------------------------------------------------------------------------
// stfw_frame_mem
// framebuffer byte store, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stfw_frame_mem
	import stfw_pkg::*;
#(
	parameter int DEPTH = DISPLAY_WIDTH_DEF * 8,
	parameter int AW    = $clog2(DISPLAY_WIDTH_DEF * 8)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/stfw_ctrl.sv @@
// ----------------------------------------------------------------------------
// stfw_ctrl
// request sequencer: clear sweep, glyph drawing, byte read, one shared address adder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stfw_ctrl
	import stfw_pkg::*;
#(
	parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
	parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF,
	localparam int PAGE_COUNT    = (DISPLAY_HEIGHT + 7) / 8,
	localparam int STORE_BYTES   = DISPLAY_WIDTH * PAGE_COUNT,
	localparam int AW            = $clog2(STORE_BYTES)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [1:0]    req_type,
	input  wire logic [7:0]    char_code,
	input  wire logic [7:0]    cursor_column,
	input  wire logic [7:0]    cursor_page,
	input  wire logic [9:0]    read_index,
	output logic               idle,
	output logic               res_valid,
	input  wire logic          res_ready,
	output res_t               res,
	output logic               mem_we,
	output logic      [AW-1:0] mem_waddr,
	output logic      [7:0]    mem_wdata,
	output logic      [AW-1:0] mem_raddr,
	input  wire logic [7:0]    mem_rdata
);

	seq_state_t  state_q, state_d;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] bot_addr_q;
	logic          clr_resp_q;
	logic [3:0]    col_q;
	logic [2:0]    page_q;
	logic [3:0]    cell_x_q;
	logic [39:0]   glyph_q;
	logic [9:0]    rindex_q;
	res_t          res_q;

	logic [AW-1:0] opb;
	logic [AW-1:0] sum;
	logic [6:0]    gcol;
	logic [7:0]    top_byte;
	logic [7:0]    low_rows;
	logic          last_x;
	logic          last_clr;

	// shared address adder
	always_comb begin
		unique case (state_q)
			ST_OFFSET: opb = AW'(int'(col_q) * CELL_PITCH);
			ST_TOP:    opb = AW'(DISPLAY_WIDTH);
			default:   opb = AW'(1);
		endcase
	end
	assign sum = addr_q + opb;

	assign gcol     = glyph_column(glyph_q, cell_x_q[3:1]);
	assign top_byte = spread_rows(gcol[3:0]);
	assign low_rows = spread_rows({1'b0, gcol[6:4]});
	assign last_x   = (cell_x_q == 4'(CELL_W - 1));
	assign last_clr = (addr_q == AW'(STORE_BYTES - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (last_clr) begin
					state_d = clr_resp_q ? ST_RESP : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (req_kind_t'(req_type))
						REQ_WRITE_CHAR: state_d = (int'(col_q) >= TEXT_COLS) ? ST_RESP : ST_BASE;
						REQ_SET_CURSOR: state_d = ST_RESP;
						REQ_CLEAR:      state_d = ST_CLEAR;
						REQ_READ_BYTE:  state_d = ST_RD_ADDR;
						default:        state_d = ST_IDLE;
					endcase
				end
			end
			ST_BASE:    state_d = ST_OFFSET;
			ST_OFFSET:  state_d = ST_TOP;
			ST_TOP:     state_d = ST_BOTTOM;
			ST_BOTTOM:  state_d = last_x ? ST_RESP : ST_TOP;
			ST_RD_ADDR: state_d = ST_RD_DATA;
			ST_RD_DATA: state_d = ST_RESP;
			ST_RESP: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		idle      = (state_q == ST_IDLE);
		res_valid = (state_q == ST_RESP);
		res       = res_q;
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		mem_raddr = addr_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_TOP: begin
				mem_we    = 1'b1;
				mem_wdata = top_byte;
				mem_raddr = sum;
			end
			ST_BOTTOM: begin
				// lower page keeps its two bottom rows
				mem_we    = 1'b1;
				mem_waddr = bot_addr_q;
				mem_wdata = {mem_rdata[7:6], low_rows[5:0]};
			end
			ST_RD_ADDR: begin
				mem_raddr = AW'(rindex_q);
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			addr_q     <= '0;
			clr_resp_q <= 1'b0;
			col_q      <= '0;
			page_q     <= '0;
			cell_x_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_CLEAR: begin
					addr_q <= sum;
					if (last_clr) begin
						clr_resp_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					cell_x_q <= '0;
					if (accept) begin
						if (req_kind_t'(req_type) == REQ_SET_CURSOR) begin
							col_q  <= (int'(cursor_column) < TEXT_COLS) ? 4'(cursor_column) : '0;
							page_q <= (int'(cursor_page) < TEXT_PAGES) ? 3'(cursor_page) : '0;
						end
						if (req_kind_t'(req_type) == REQ_CLEAR) begin
							addr_q     <= '0;
							clr_resp_q <= 1'b1;
						end
					end
				end
				ST_BASE: begin
					addr_q <= AW'(int'(page_q) * DISPLAY_WIDTH);
				end
				ST_OFFSET: begin
					addr_q <= sum;
				end
				ST_BOTTOM: begin
					addr_q   <= sum;
					cell_x_q <= cell_x_q + 4'd1;
					if (last_x) begin
						col_q <= col_q + 4'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			glyph_q          <= FONT[glyph_index(char_code)];
			rindex_q         <= read_index;
			res_q.read_data  <= '0;
			res_q.status     <= (req_kind_t'(req_type) == REQ_WRITE_CHAR)
			                    && (int'(col_q) >= TEXT_COLS);
		end
		if (state_q == ST_TOP) begin
			bot_addr_q <= sum;
		end
		if (state_q == ST_RD_DATA) begin
			res_q.read_data <= (int'(rindex_q) < STORE_BYTES) ? mem_rdata : '0;
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the scaled text framebuffer writer: a queue-fed
// request driver and a result monitor run against a shadow framebuffer that
// draws every glyph itself, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------

module tb;

	import stfw_pkg::*;

	// display geometry used for both the block and the shadow image
	localparam int FB_WIDTH    = 128;
	localparam int FB_HEIGHT   = 64;
	localparam int FB_PAGES    = (FB_HEIGHT + 7) / 8;
	localparam int STORE_BYTES = FB_WIDTH * FB_PAGES;
	localparam int CELL_H      = 14;

	// run control
	localparam int RANDOM_REQUESTS = 1850;
	localparam int STALL_LIMIT     = 20000;
	localparam int DRAIN_CYCLES    = 40;
	localparam int LONG_HOLD       = 400;
	localparam int LONG_HOLD_AFTER = 100;

	// glyph columns, leftmost column in the top byte, bit 0 is the top row
	localparam logic [39:0] DIGIT_GLYPHS [10] = '{
		40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
		40'h3649494936, 40'h064949291E
	};
	localparam logic [39:0] LETTER_GLYPHS [26] = '{
		40'h7E1111117E, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C,
		40'h7F49494941, 40'h7F09090901, 40'h3E4149497A, 40'h7F0808087F,
		40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
		40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906,
		40'h3E4151215E, 40'h7F09192946, 40'h4649494931, 40'h01017F0101,
		40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F, 40'h6314081463,
		40'h0708700807, 40'h6151494543
	};
	localparam logic [39:0] COLON_GLYPH = 40'h0036360000;
	localparam logic [39:0] DASH_GLYPH  = 40'h0808080800;

	typedef struct {
		req_kind_t  kind;
		logic [7:0] char_code;
		logic [7:0] cursor_column;
		logic [7:0] cursor_page;
		logic [9:0] read_index;
		int         gap_after;    // idle cycles after this beat is accepted
		bit         drain_first;  // hold this beat until every result is back
	} request_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	stfw_req_if req_bus ();
	stfw_rsp_if rsp_bus ();

	scaled_text_framebuffer_writer #(
		.DISPLAY_WIDTH  (FB_WIDTH),
		.DISPLAY_HEIGHT (FB_HEIGHT)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// driven copies of the block inputs, known from time zero
	logic       send_valid = 1'b0;
	request_t   send_beat  = '{REQ_WRITE_CHAR, 8'd0, 8'd0, 8'd0, 10'd0, 0, 1'b0};
	logic       take_ready = 1'b0;

	assign req_bus.valid         = send_valid;
	assign req_bus.req_type      = send_beat.kind;
	assign req_bus.char_code     = send_beat.char_code;
	assign req_bus.cursor_column = send_beat.cursor_column;
	assign req_bus.cursor_page   = send_beat.cursor_page;
	assign req_bus.read_index    = send_beat.read_index;
	assign rsp_bus.ready         = take_ready;

	// shadow of the block state
	logic [7:0] frame_image [STORE_BYTES];
	logic [3:0] shadow_col  = 4'd0;
	logic [2:0] shadow_page = 3'd0;

	request_t pending_requests [$];
	res_t     expected_results [$];

	int  errors        = 0;
	int  queued_count  = 0;
	int  results_seen  = 0;
	int  gap_left      = 0;
	int  stall_left    = 0;
	int  rx_cycles     = 0;
	int  idle_cycles   = 0;
	bit  hold_armed    = 1'b1;
	bit  sender_calm   = 1'b0;
	res_t head_result;

	initial begin
		foreach (frame_image[i]) begin
			frame_image[i] = 8'd0;
		end
	end

	// clock and the single reset pulse
	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 88) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// drawable characters most of the time, any code otherwise
	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 4))
			0: return 8'(8'h30 + $urandom_range(0, 9));
			1: return 8'(8'h41 + $urandom_range(0, 25));
			2: return 8'(8'h61 + $urandom_range(0, 25));
			3: return $urandom_range(0, 1) ? 8'h3A : 8'h2D;
			default: return 8'($urandom);
		endcase
	endfunction

	// font lookup, lower case shares the upper case shapes
	function automatic logic [39:0] glyph_for(input logic [7:0] code);
		logic [7:0] c;
		c = code;
		if (c >= 8'h30 && c <= 8'h39) return DIGIT_GLYPHS[c - 8'h30];
		if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
		if (c >= 8'h41 && c <= 8'h5A) return LETTER_GLYPHS[c - 8'h41];
		if (c == 8'h3A) return COLON_GLYPH;
		if (c == 8'h2D) return DASH_GLYPH;
		return 40'd0;
	endfunction

	// apply one request to the shadow state and give back its result
	function automatic res_t apply_request(input request_t rq);
		res_t        r;
		logic [39:0] g;
		int          bx;
		int          by;
		int          px;
		int          py;
		r = '0;
		case (rq.kind)
			REQ_WRITE_CHAR: begin
				if (shadow_col >= TEXT_COLS || shadow_page >= TEXT_PAGES) begin
					// cursor off the text grid: nothing drawn, cursor kept
					r.status = 1'b1;
				end else begin
					g  = glyph_for(rq.char_code);
					bx = int'(shadow_col) * CELL_PITCH;
					by = int'(shadow_page) * 8;
					// every glyph dot becomes a 2x2 block, all 140 pixels rewritten
					for (int y = 0; y < CELL_H; y++) begin
						for (int x = 0; x < CELL_W; x++) begin
							px = bx + x;
							py = by + y;
							if (px < FB_WIDTH && py < FB_HEIGHT) begin
								frame_image[(py / 8) * FB_WIDTH + px][py % 8] =
									g[8 * (4 - x / 2) + y / 2];
							end
						end
					end
					shadow_col = shadow_col + 4'd1;
				end
			end
			REQ_SET_CURSOR: begin
				// out-of-range cursor values fall back to zero
				shadow_col  = (rq.cursor_column < TEXT_COLS) ? rq.cursor_column[3:0] : 4'd0;
				shadow_page = (rq.cursor_page < TEXT_PAGES) ? rq.cursor_page[2:0] : 3'd0;
			end
			REQ_CLEAR: begin
				foreach (frame_image[i]) begin
					frame_image[i] = 8'd0;
				end
			end
			default: begin
				if (int'(rq.read_index) < STORE_BYTES) begin
					r.read_data = frame_image[rq.read_index];
				end
			end
		endcase
		return r;
	endfunction

	task automatic add_request(input req_kind_t kind, input logic [7:0] code,
			input logic [7:0] col, input logic [7:0] page, input logic [9:0] addr,
			input bit drain);
		request_t rq;
		rq.kind          = kind;
		rq.char_code     = code;
		rq.cursor_column = col;
		rq.cursor_page   = page;
		rq.read_index    = addr;
		rq.gap_after     = sender_calm ? 0 : pick_gap();
		rq.drain_first   = drain;
		pending_requests.push_back(rq);
		queued_count++;
	endtask

	// read back a byte near the current text row, sometimes anywhere
	task automatic queue_probe(input int page);
		int addr;
		if ($urandom_range(0, 9) < 3) begin
			addr = $urandom_range(0, STORE_BYTES - 1);
		end else begin
			addr = (page + $urandom_range(0, 1)) * FB_WIDTH
				+ $urandom_range(0, TEXT_COLS - 1) * CELL_PITCH + $urandom_range(0, 10);
		end
		add_request(REQ_READ_BYTE, 8'($urandom), 8'($urandom), 8'($urandom),
			10'(addr), 1'b0);
	endtask

	// request driver: next beat goes out once the current one is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (send_valid && req_bus.ready) begin
				expected_results.push_back(apply_request(send_beat));
			end
			if (!send_valid || req_bus.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					send_valid <= 1'b0;
				end else if (pending_requests.size() != 0 &&
						!(pending_requests[0].drain_first && expected_results.size() != 0)) begin
					send_beat  <= pending_requests[0];
					gap_left   = pending_requests[0].gap_after;
					void'(pending_requests.pop_front());
					send_valid <= 1'b1;
				end else begin
					send_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			rx_cycles++;
			if (rsp_bus.valid && take_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected: read_data %02h status %0b",
						rsp_bus.read_data, rsp_bus.status);
					errors++;
				end else begin
					head_result = expected_results.pop_front();
					if (rsp_bus.read_data !== head_result.read_data) begin
						$error("read_data mismatch: expected %02h, actual %02h",
							head_result.read_data, rsp_bus.read_data);
						errors++;
					end
					if (rsp_bus.status !== head_result.status) begin
						$error("status mismatch: expected %0b, actual %0b",
							head_result.status, rsp_bus.status);
						errors++;
					end
				end
			end
			// one long hold-off so the block backs up into the request side
			if (hold_armed && results_seen >= LONG_HOLD_AFTER) begin
				hold_armed = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				take_ready <= 1'b0;
			end else begin
				take_ready <= 1'b1;
				// quiet windows with no stalls at all
				if ((rx_cycles % 5000) >= 1200) begin
					stall_left = pick_gap();
				end
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((send_valid && req_bus.ready) || (rsp_bus.valid && take_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	// stimulus: directed sequence, then random text scenes
	initial begin
		int roll;
		int n_writes;
		int col_sel;
		int page_sel;
		int gen_page;
		int burst;

		// empty buffer after the reset sweep, both ends of the store
		add_request(REQ_READ_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 10'd0, 1'b0);
		add_request(REQ_READ_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 10'd1023, 1'b0);
		// one of each glyph family along the top row
		add_request(REQ_WRITE_CHAR, 8'h30, 8'($urandom), 8'($urandom), 10'($urandom), 1'b0);
		add_request(REQ_WRITE_CHAR, 8'h41, 8'($urandom), 8'($urandom), 10'($urandom), 1'b0);
		add_request(REQ_WRITE_CHAR, 8'h61, 8'($urandom), 8'($urandom), 10'($urandom), 1'b0);
		add_request(REQ_WRITE_CHAR, 8'h3A, 8'($urandom), 8'($urandom), 10'($urandom), 1'b0);
		add_request(REQ_WRITE_CHAR, 8'h2D, 8'($urandom), 8'($urandom), 10'($urandom), 1'b0);
		add_request(REQ_WRITE_CHAR, 8'hFF, 8'($urandom), 8'($urandom), 10'($urandom), 1'b0);
		add_request(REQ_WRITE_CHAR, 8'h5A, 8'($urandom), 8'($urandom), 10'($urandom), 1'b0);
		add_request(REQ_WRITE_CHAR, 8'h7A, 8'($urandom), 8'($urandom), 10'($urandom), 1'b0);
		add_request(REQ_WRITE_CHAR, 8'h39, 8'($urandom), 8'($urandom), 10'($urandom), 1'b0);
		add_request(REQ_WRITE_CHAR, 8'h4D, 8'($urandom), 8'($urandom), 10'($urandom), 1'b0);
		// last text column of the row
		add_request(REQ_WRITE_CHAR, 8'h58, 8'($urandom), 8'($urandom), 10'($urandom), 1'b0);
		// cursor has run off the row: ignored
		add_request(REQ_WRITE_CHAR, 8'h4B, 8'($urandom), 8'($urandom), 10'($urandom), 1'b0);
		add_request(REQ_READ_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 10'd0, 1'b0);
		add_request(REQ_READ_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 10'd238, 1'b0);
		// last column of the last text row reaches the bottom page
		add_request(REQ_SET_CURSOR, 8'($urandom), 8'd10, 8'd6, 10'($urandom), 1'b0);
		add_request(REQ_WRITE_CHAR, 8'h57, 8'($urandom), 8'($urandom), 10'($urandom), 1'b0);
		add_request(REQ_READ_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 10'd1009, 1'b0);
		add_request(REQ_WRITE_CHAR, 8'h38, 8'($urandom), 8'($urandom), 10'($urandom), 1'b0);
		// out-of-range cursor values fold to the origin
		add_request(REQ_SET_CURSOR, 8'($urandom), 8'd255, 8'd255, 10'($urandom), 1'b0);
		add_request(REQ_WRITE_CHAR, 8'h00, 8'($urandom), 8'($urandom), 10'($urandom), 1'b0);
		add_request(REQ_READ_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 10'd0, 1'b0);
		add_request(REQ_SET_CURSOR, 8'($urandom), 8'd11, 8'd7, 10'($urandom), 1'b1);
		// sender waits for everything outstanding, then wipes the buffer
		add_request(REQ_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 10'($urandom), 1'b1);
		add_request(REQ_READ_BYTE, 8'($urandom), 8'($urandom), 8'($urandom), 10'd883, 1'b0);

		queued_count = 0;
		while (queued_count < RANDOM_REQUESTS) begin
			sender_calm = ((queued_count / 150) % 4) == 3;
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				// noise: any kind, any field values
				burst = $urandom_range(1, 6);
				repeat (burst) begin
					add_request(req_kind_t'($urandom_range(0, 3)), 8'($urandom),
						8'($urandom), 8'($urandom), 10'($urandom), 1'b0);
				end
			end else if (roll < 12) begin
				add_request(REQ_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
					10'($urandom), $urandom_range(0, 1));
			end else begin
				// a text line: place the cursor, write a run, probe the cells
				col_sel  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
					: $urandom_range(0, TEXT_COLS - 1);
				page_sel = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
					: $urandom_range(0, TEXT_PAGES - 1);
				gen_page = (page_sel < TEXT_PAGES) ? page_sel : 0;
				add_request(REQ_SET_CURSOR, 8'($urandom), 8'(col_sel), 8'(page_sel),
					10'($urandom), roll < 14);
				n_writes = $urandom_range(1, 13);
				repeat (n_writes) begin
					add_request(REQ_WRITE_CHAR, pick_char(), 8'($urandom), 8'($urandom),
						10'($urandom), 1'b0);
					if ($urandom_range(0, 9) < 4) begin
						queue_probe(gen_page);
					end
				end
				repeat ($urandom_range(1, 3)) begin
					queue_probe(gen_page);
				end
			end
		end

		// all stimulus taken and answered, then a quiet tail for stray beats
		do begin
			@(posedge clk);
		end while (pending_requests.size() != 0 || send_valid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/stfw_pkg.sv
rtl/stfw_req_if.sv
rtl/stfw_rsp_if.sv
rtl/stfw_frame_mem.sv
rtl/stfw_ctrl.sv
rtl/scaled_text_framebuffer_writer.sv
tb/sv/tb.sv
